@@ rtl/core/ufd_pkg.sv @@
// Shared types and constants for the update frame decoder.
// Depends on nothing; imported by every module under rtl/core.
package ufd_pkg;

	// Frame layout constants
	localparam logic [7:0]  HEAD_BYTE = 8'h50;
	localparam logic [7:0]  TAIL_BYTE = 8'h43;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] OVERHEAD  = 16'd9;
	localparam int unsigned MAX_FRAME = 512;
	localparam logic [16:0] MAX_FRAME_W = 17'(MAX_FRAME);

	// Status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_BAD_HEAD = 3'd1;
	localparam status_t ST_BAD_LEN  = 3'd2;
	localparam status_t ST_BAD_CRC  = 3'd3;
	localparam status_t ST_BAD_TAIL = 3'd4;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEAD,
		PH_LEN,
		PH_CMD,
		PH_PAY,
		PH_CRC,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] command;
		logic [8:0] payload_length;
		status_t    status;
		logic       last;
	} result_t;

endpackage

@@ rtl/core/ufd_crc.sv @@
// One-byte CRC-16/MODBUS update, eight unrolled shift steps.
// Depends on ufd_pkg for the polynomial.
module ufd_crc (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import ufd_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

@@ rtl/core/ufd_parse.sv @@
// Frame parser: phase machine, length and CRC tracking, result build.
// Depends on ufd_pkg and ufd_crc.
module ufd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       rx_byte,
	input  logic             buffer_start,
	output logic             res_valid,
	output ufd_pkg::result_t res
);
	import ufd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  crc_hi_q, crc_hi_d;

	// State as seen by this byte (a start flag wipes it)
	phase_t      ph_e;
	logic [15:0] pos_e, len_e, crc_e;
	logic [7:0]  cmd_e, crc_hi_e;
	logic [15:0] crc_upd;
	logic [15:0] pos_inc;
	logic [15:0] len_full;
	logic [8:0]  pay_len;

	ufd_crc u_crc (
		.crc_in (crc_e),
		.data   (rx_byte),
		.crc_out(crc_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			pos_q    <= '0;
			len_q    <= '0;
			crc_q    <= CRC_INIT;
			cmd_q    <= '0;
			crc_hi_q <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			cmd_q    <= cmd_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	always_comb begin
		ph_e     = buffer_start ? PH_HEAD : phase_q;
		pos_e    = buffer_start ? 16'd0 : pos_q;
		len_e    = buffer_start ? 16'd0 : len_q;
		crc_e    = buffer_start ? CRC_INIT : crc_q;
		cmd_e    = buffer_start ? 8'd0 : cmd_q;
		crc_hi_e = buffer_start ? 8'd0 : crc_hi_q;
		pos_inc  = pos_e + 16'd1;
		len_full = len_e | {8'h00, rx_byte};
		pay_len  = 9'(len_e - OVERHEAD);

		phase_d  = ph_e;
		pos_d    = pos_e;
		len_d    = len_e;
		crc_d    = crc_e;
		cmd_d    = cmd_e;
		crc_hi_d = crc_hi_e;

		res_valid          = 1'b0;
		res.kind           = KIND_STATUS;
		res.payload_byte   = 8'd0;
		res.command        = cmd_e;
		res.payload_length = pay_len;
		res.status         = ST_OK;
		res.last           = 1'b1;

		case (ph_e)
			PH_HEAD: begin
				if (rx_byte != HEAD_BYTE) begin
					res_valid          = 1'b1;
					res.status         = ST_BAD_HEAD;
					res.command        = 8'd0;
					res.payload_length = 9'd0;
					phase_d            = PH_HUNT;
				end else begin
					pos_d = pos_inc;
					if (pos_inc == 16'd2) begin
						phase_d = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				pos_d = pos_inc;
				if (pos_e == 16'd2) begin
					len_d = {rx_byte, 8'h00};
				end else begin
					len_d = len_full;
					if (len_full < OVERHEAD || {1'b0, len_full} > MAX_FRAME_W) begin
						res_valid          = 1'b1;
						res.status         = ST_BAD_LEN;
						res.command        = 8'd0;
						res.payload_length = 9'd0;
						phase_d            = PH_HUNT;
					end else begin
						phase_d = PH_CMD;
					end
				end
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				pos_d   = pos_inc;
				phase_d = (len_e == OVERHEAD) ? PH_CRC : PH_PAY;
			end
			PH_PAY: begin
				crc_d            = crc_upd;
				pos_d            = pos_inc;
				if (pos_inc == len_e - 16'd4) begin
					phase_d = PH_CRC;
				end
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
				res.command      = 8'd0;
				res.payload_length = 9'd0;
				res.last         = 1'b0;
			end
			PH_CRC: begin
				pos_d = pos_inc;
				if (pos_e == len_e - 16'd4) begin
					crc_hi_d = rx_byte;
				end else if (crc_hi_e == crc_e[15:8] && rx_byte == crc_e[7:0]) begin
					phase_d = PH_TAIL;
				end else begin
					res_valid  = 1'b1;
					res.status = ST_BAD_CRC;
					phase_d    = PH_HUNT;
				end
			end
			PH_TAIL: begin
				if (rx_byte != TAIL_BYTE) begin
					res_valid  = 1'b1;
					res.status = ST_BAD_TAIL;
					phase_d    = PH_HUNT;
				end else begin
					pos_d = pos_inc;
					if (pos_inc == len_e) begin
						res_valid = 1'b1;
						phase_d   = PH_HUNT;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

endmodule

@@ rtl/core/ufd_outbuf.sv @@
// Result register with one skid entry; parts the parser from the receiver.
// Depends on ufd_pkg for the result type.
module ufd_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ufd_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output ufd_pkg::result_t out_data
);
	import ufd_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

@@ rtl/core/update_frame_decoder_core.sv @@
// Top level of the update frame decoder: parser plus result buffer.
// Depends on ufd_pkg, ufd_parse (with ufd_crc) and ufd_outbuf.
//
// Usage
//   Input channel: one received byte per transfer (rx_byte), with
//   buffer_start high on the first byte of a buffer; that byte restarts
//   parsing and drops any unfinished frame silently.
//   Output channel: at most one result per input byte. kind 0 carries a
//   payload byte; kind 1 (last high) closes the frame with status,
//   command and payload length.
//   Each result is registered, in the result register or in the skid entry.
//   Throughput: one byte per cycle while in_stall is low; the CRC byte update
//   is an unrolled eight-step network between the parser state registers.
//   Stall: the result register is backed by one skid entry, so a byte is
//   still taken while a result waits; in_stall rises only when both are
//   occupied and falls the cycle after the receiver takes a result.
//   Reset (arst_n low): parser hunts for a start flag, output empty,
//   in_stall low. Bytes before the first start flag are dropped.
module update_frame_decoder_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	input  logic             buffer_start,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             kind,
	output logic [7:0]       payload_byte,
	output logic [7:0]       command,
	output logic [8:0]       payload_length,
	output ufd_pkg::status_t status,
	output logic             last
);
	import ufd_pkg::*;

	logic    acc;
	logic    res_valid;
	result_t res, out_res;
	logic    buf_full;

	// A byte transfers whenever the skid entry is free
	assign in_stall = buf_full;
	assign acc      = in_valid && !buf_full;

	ufd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.rx_byte     (rx_byte),
		.buffer_start(buffer_start),
		.res_valid   (res_valid),
		.res         (res)
	);

	ufd_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc && res_valid),
		.push_data(res),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_res)
	);

	assign kind           = out_res.kind;
	assign payload_byte   = out_res.payload_byte;
	assign command        = out_res.command;
	assign payload_length = out_res.payload_length;
	assign status         = out_res.status;
	assign last           = out_res.last;

	// Skid entry only fills behind an occupied result register
	a_skid_behind_out : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid entry held while result register empty");

	// Frame close flag only on status results
	a_last_is_status : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_STATUS)
		else $error("last set on a payload result");

	// Payload results carry no status
	a_payload_clean : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |-> status == ST_OK && !last)
		else $error("payload result with status");

	// Header and length errors report no frame details
	a_early_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_HEAD || status == ST_BAD_LEN)
		|-> command == 8'd0 && payload_length == 9'd0)
		else $error("frame details on header or length error");

endmodule
